[hw/rtl/cau_pkg.sv]
`timescale 1ns / 1ps
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic dz;
    logic ovf;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
  } ctrl_t;

endpackage

[hw/rtl/cau_front.sv]
`timescale 1ns / 1ps
module cau_front #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [1:0]                            kind,
  input  logic signed [DATA_WIDTH-1:0]          a_real,
  input  logic signed [DATA_WIDTH-1:0]          a_imag,
  input  logic signed [DATA_WIDTH-1:0]          b_real,
  input  logic signed [DATA_WIDTH-1:0]          b_imag,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]       rem_re,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]       rem_im,
  output logic [2*DATA_WIDTH-1:0]               den,
  output logic signed [DATA_WIDTH-1:0]          m_re,
  output logic signed [DATA_WIDTH-1:0]          m_im,
  output cau_pkg::ctrl_t                        ctrl
);
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int NW = 2 * DATA_WIDTH + 1 + FRAC_BITS;
  localparam int QW = DATA_WIDTH + 1;
  localparam logic signed [PW:0] MAXV = (PW+1)'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic signed [PW:0] MINV = -MAXV - (PW+1)'(1);

  function automatic logic [DW:0] sat(input logic signed [PW:0] v);
    logic [DW:0] r;
    if (v > MAXV) r = {1'b1, MAXV[DW-1:0]};
    else if (v < MINV) r = {1'b1, MINV[DW-1:0]};
    else r = {1'b0, v[DW-1:0]};
    return r;
  endfunction

  // stage 1: products and add/sub
  logic signed [PW-1:0] p_ac, p_bd, p_ad, p_bc, p_cc, p_dd;
  logic signed [DW:0]   as_re, as_im;
  kind_t                k1;
  logic                 v1, dz1;
  logic signed [DW:0]   as_re_next, as_im_next;
  kind_t                k_in;

  always_comb begin
    k_in = kind_t'(kind);
    if (k_in == KIND_SUB) begin
      as_re_next = {a_real[DW-1], a_real} - {b_real[DW-1], b_real};
      as_im_next = {a_imag[DW-1], a_imag} - {b_imag[DW-1], b_imag};
    end else begin
      as_re_next = {a_real[DW-1], a_real} + {b_real[DW-1], b_real};
      as_im_next = {a_imag[DW-1], a_imag} + {b_imag[DW-1], b_imag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      p_ac  <= a_real * b_real;
      p_bd  <= a_imag * b_imag;
      p_ad  <= a_real * b_imag;
      p_bc  <= a_imag * b_real;
      p_cc  <= b_real * b_real;
      p_dd  <= b_imag * b_imag;
      as_re <= as_re_next;
      as_im <= as_im_next;
      k1    <= k_in;
      dz1   <= (b_real == '0) && (b_imag == '0);
    end
  end

  // stage 2: sums, non-divide results
  logic signed [PW:0] ac_x, bd_x, ad_x, bc_x, mre, mim, sel_re, sel_im;
  logic signed [PW:0] n_re, n_im, n_re_next, n_im_next;
  logic [PW-1:0]      den2, den2_next;
  logic [DW:0]        sr, si;
  logic signed [DW-1:0] m2_re, m2_im;
  logic               v2, dz2, div2, ovf2;

  always_comb begin
    ac_x = {p_ac[PW-1], p_ac};
    bd_x = {p_bd[PW-1], p_bd};
    ad_x = {p_ad[PW-1], p_ad};
    bc_x = {p_bc[PW-1], p_bc};
    mre = ac_x - bd_x;
    mim = ad_x + bc_x;
    n_re_next = ac_x + bd_x;
    n_im_next = bc_x - ad_x;
    den2_next = $unsigned(p_cc) + $unsigned(p_dd);
    if (k1 == KIND_MUL) begin
      sel_re = mre >>> FRAC_BITS;
      sel_im = mim >>> FRAC_BITS;
    end else begin
      sel_re = {{(PW-DW){as_re[DW]}}, as_re};
      sel_im = {{(PW-DW){as_im[DW]}}, as_im};
    end
    sr = sat(sel_re);
    si = sat(sel_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      n_re  <= n_re_next;
      n_im  <= n_im_next;
      den2  <= den2_next;
      m2_re <= sr[DW-1:0];
      m2_im <= si[DW-1:0];
      ovf2  <= sr[DW] | si[DW];
      dz2   <= dz1;
      div2  <= (k1 == KIND_DIV);
    end
  end

  // stage 3: magnitudes and quotient range check
  logic [NW-1:0] num_re, num_im, mag_re, mag_im;
  logic          big_re, big_im;

  always_comb begin
    num_re = NW'(n_re) << FRAC_BITS;
    num_im = NW'(n_im) << FRAC_BITS;
    mag_re = n_re[PW] ? (~num_re + NW'(1)) : num_re;
    mag_im = n_im[PW] ? (~num_im + NW'(1)) : num_im;
    big_re = (mag_re >> QW) >= NW'(den2);
    big_im = (mag_im >> QW) >= NW'(den2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.valid <= 1'b0;
    end else if (en) begin
      ctrl.valid <= v2;
    end
    if (en) begin
      rem_re      <= mag_re;
      rem_im      <= mag_im;
      den         <= den2;
      m_re        <= m2_re;
      m_im        <= m2_im;
      ctrl.is_div <= div2;
      ctrl.dz     <= dz2;
      ctrl.ovf    <= ovf2;
      ctrl.neg_re <= n_re[PW];
      ctrl.neg_im <= n_im[PW];
      ctrl.big_re <= big_re;
      ctrl.big_im <= big_im;
    end
  end

endmodule

[hw/rtl/cau_div_cell.sv]
`timescale 1ns / 1ps
module cau_div_cell #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
  parameter int BIT        = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0]   rem_re_i,
  input  logic [2*DATA_WIDTH+FRAC_BITS:0]   rem_im_i,
  input  logic [DATA_WIDTH:0]               q_re_i,
  input  logic [DATA_WIDTH:0]               q_im_i,
  input  logic [2*DATA_WIDTH-1:0]           den_i,
  input  logic signed [DATA_WIDTH-1:0]      m_re_i,
  input  logic signed [DATA_WIDTH-1:0]      m_im_i,
  input  cau_pkg::ctrl_t                    ctrl_i,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]   rem_re_o,
  output logic [2*DATA_WIDTH+FRAC_BITS:0]   rem_im_o,
  output logic [DATA_WIDTH:0]               q_re_o,
  output logic [DATA_WIDTH:0]               q_im_o,
  output logic [2*DATA_WIDTH-1:0]           den_o,
  output logic signed [DATA_WIDTH-1:0]      m_re_o,
  output logic signed [DATA_WIDTH-1:0]      m_im_o,
  output cau_pkg::ctrl_t                    ctrl_o
);
  import cau_pkg::*;

  localparam int NW = 2 * DATA_WIDTH + 1 + FRAC_BITS;
  localparam int QW = DATA_WIDTH + 1;
  localparam int EW = NW + QW;

  logic [EW-1:0] dsh, re_x, im_x;
  logic          ge_re, ge_im;
  logic [NW-1:0] rem_re_next, rem_im_next;

  always_comb begin
    dsh   = EW'(den_i) << BIT;
    re_x  = EW'(rem_re_i);
    im_x  = EW'(rem_im_i);
    ge_re = re_x >= dsh;
    ge_im = im_x >= dsh;
    rem_re_next = ge_re ? NW'(re_x - dsh) : rem_re_i;
    rem_im_next = ge_im ? NW'(im_x - dsh) : rem_im_i;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_o.valid <= 1'b0;
    end else if (en) begin
      ctrl_o.valid <= ctrl_i.valid;
    end
    if (en) begin
      rem_re_o <= rem_re_next;
      rem_im_o <= rem_im_next;
      q_re_o   <= q_re_i | (QW'(ge_re) << BIT);
      q_im_o   <= q_im_i | (QW'(ge_im) << BIT);
      den_o    <= den_i;
      m_re_o   <= m_re_i;
      m_im_o   <= m_im_i;
      ctrl_o.is_div <= ctrl_i.is_div;
      ctrl_o.dz     <= ctrl_i.dz;
      ctrl_o.ovf    <= ctrl_i.ovf;
      ctrl_o.neg_re <= ctrl_i.neg_re;
      ctrl_o.neg_im <= ctrl_i.neg_im;
      ctrl_o.big_re <= ctrl_i.big_re;
      ctrl_o.big_im <= ctrl_i.big_im;
    end
  end

endmodule

[hw/rtl/cau_back.sv]
`timescale 1ns / 1ps
module cau_back #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [DATA_WIDTH:0]           q_re,
  input  logic [DATA_WIDTH:0]           q_im,
  input  logic signed [DATA_WIDTH-1:0]  m_re,
  input  logic signed [DATA_WIDTH-1:0]  m_im,
  input  cau_pkg::ctrl_t                ctrl,
  output logic                          out_valid,
  output logic signed [DATA_WIDTH-1:0]  res_real,
  output logic signed [DATA_WIDTH-1:0]  res_imag,
  output logic                          overflow,
  output logic                          divide_by_zero
);
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int QW = DATA_WIDTH + 1;
  localparam logic signed [QW:0] MAXD = (QW+1)'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic signed [QW:0] MIND = -MAXD - (QW+1)'(1);

  function automatic logic [DW:0] fin(input logic [QW-1:0] q, input logic neg,
                                      input logic big);
    logic signed [QW:0] s;
    logic [DW:0]        r;
    s = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (big) r = neg ? {1'b1, MIND[DW-1:0]} : {1'b1, MAXD[DW-1:0]};
    else if (s > MAXD) r = {1'b1, MAXD[DW-1:0]};
    else if (s < MIND) r = {1'b1, MIND[DW-1:0]};
    else r = {1'b0, s[DW-1:0]};
    return r;
  endfunction

  logic [DW:0] fr, fi;
  logic signed [DW-1:0] re_next, im_next;
  logic ovf_next;

  always_comb begin
    fr = fin(q_re, ctrl.neg_re, ctrl.big_re);
    fi = fin(q_im, ctrl.neg_im, ctrl.big_im);
    if (!ctrl.is_div) begin
      re_next  = m_re;
      im_next  = m_im;
      ovf_next = ctrl.ovf;
    end else if (ctrl.dz) begin
      re_next  = '0;
      im_next  = '0;
      ovf_next = 1'b0;
    end else begin
      re_next  = fr[DW-1:0];
      im_next  = fi[DW-1:0];
      ovf_next = fr[DW] | fi[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctrl.valid;
    end
    if (en) begin
      res_real       <= re_next;
      res_imag       <= im_next;
      overflow       <= ovf_next;
      divide_by_zero <= ctrl.is_div & ctrl.dz;
    end
  end

endmodule

[hw/rtl/complex_arithmetic_unit_top.sv]
`timescale 1ns / 1ps
// channel | handshake            | payload
// input   | in_valid / in_ready  | kind, a_real, a_imag, b_real, b_imag
// output  | out_valid / out_ready| res_real, res_imag, overflow, divide_by_zero
//
// one transaction per cycle while the output is not stalled
// pipeline: product, sum and range-check stages, a divider chain with one cell
// per quotient bit (DATA_WIDTH + 1 cells), then an output stage
// synchronous reset empties the pipeline
// the whole pipeline holds while the output transaction is stalled
module complex_arithmetic_unit_top #(
  parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic signed [DATA_WIDTH-1:0]  a_real,
  input  logic signed [DATA_WIDTH-1:0]  a_imag,
  input  logic signed [DATA_WIDTH-1:0]  b_real,
  input  logic signed [DATA_WIDTH-1:0]  b_imag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  res_real,
  output logic signed [DATA_WIDTH-1:0]  res_imag,
  output logic                          overflow,
  output logic                          divide_by_zero
);
  import cau_pkg::*;

  localparam int NW = 2 * DATA_WIDTH + 1 + FRAC_BITS;
  localparam int QW = DATA_WIDTH + 1;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  logic [NW-1:0]               rem_re [QW+1];
  logic [NW-1:0]               rem_im [QW+1];
  logic [QW-1:0]               q_re   [QW+1];
  logic [QW-1:0]               q_im   [QW+1];
  logic [2*DATA_WIDTH-1:0]     den    [QW+1];
  logic signed [DATA_WIDTH-1:0] m_re  [QW+1];
  logic signed [DATA_WIDTH-1:0] m_im  [QW+1];
  ctrl_t                       ctrl   [QW+1];

  cau_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid), .kind(kind),
    .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .rem_re(rem_re[0]), .rem_im(rem_im[0]), .den(den[0]),
    .m_re(m_re[0]), .m_im(m_im[0]), .ctrl(ctrl[0])
  );

  assign q_re[0] = '0;
  assign q_im[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    cau_div_cell #(
      .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .BIT(QW - 1 - i)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .rem_re_i(rem_re[i]), .rem_im_i(rem_im[i]),
      .q_re_i(q_re[i]), .q_im_i(q_im[i]), .den_i(den[i]),
      .m_re_i(m_re[i]), .m_im_i(m_im[i]), .ctrl_i(ctrl[i]),
      .rem_re_o(rem_re[i+1]), .rem_im_o(rem_im[i+1]),
      .q_re_o(q_re[i+1]), .q_im_o(q_im[i+1]), .den_o(den[i+1]),
      .m_re_o(m_re[i+1]), .m_im_o(m_im[i+1]), .ctrl_o(ctrl[i+1])
    );
  end

  cau_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst(rst), .en(en),
    .q_re(q_re[QW]), .q_im(q_im[QW]), .m_re(m_re[QW]), .m_im(m_im[QW]),
    .ctrl(ctrl[QW]), .out_valid(out_valid), .res_real(res_real),
    .res_imag(res_imag), .overflow(overflow), .divide_by_zero(divide_by_zero)
  );

`ifndef SYNTHESIS
  a_dz_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_by_zero |-> !overflow && res_real == '0 && res_imag == '0)
    else $error("divide by zero result not clean");
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("pipeline held without output stall");
`endif

endmodule
